FILE: rtl/core/stui_pkg.sv
// Shared types and constants for the scanline timer and interrupt unit.
// No dependencies.
`default_nettype none

package stui_pkg;

	localparam int unsigned LINES_PER_FRAME = 264;
	localparam int unsigned VBLANK_LINE     = 224;
	localparam int unsigned TICKS_PER_LINE  = 384;
	localparam int unsigned BORDER_LINES    = 8;

	localparam int unsigned LINE_W   = 9;
	localparam int unsigned TIMER_W  = 32;
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned MASK_W   = 3;

	localparam int unsigned ACK_VBLANK_BIT = 2;
	localparam int unsigned ACK_TIMER_BIT  = 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_RELOAD = 2'd1,
		CMD_ACK    = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [TIMER_W-1:0] reload_value;
		logic [MASK_W-1:0]  ack_mask;
	} item_t;

	typedef struct packed {
		logic               vblank_pending;
		logic               timer_pending;
		logic [LINE_W-1:0]  line_now;
		logic [TIMER_W-1:0] timer_now;
	} result_t;

	typedef struct packed {
		logic  advance;
		item_t item;
	} step_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/scanline_timer_irq_unit.sv
// Top level of the scanline timer and interrupt unit: input and result
// registers around the event logic. Depends on stui_pkg and stui_step.
// Path: an input beat reaches the result beat through the input register, then the result register.
// Throughput: one event per cycle while out_stall is low; the result register frees when its beat is taken.
// Reset: line, timer, reload and both pending flags clear to zero; the latched stop_at_border setting clears.
`default_nettype none

module scanline_timer_irq_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire [stui_pkg::CMD_W-1:0]         cmd,
	input  wire [stui_pkg::TIMER_W-1:0]       reload_value,
	input  wire [stui_pkg::MASK_W-1:0]        ack_mask,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic                              vblank_pending,
	output logic                              timer_pending,
	output logic [stui_pkg::LINE_W-1:0]       line_now,
	output logic [stui_pkg::TIMER_W-1:0]      timer_now,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire                               stop_at_border
);

	logic                 valid_s1;
	stui_pkg::item_t      item_s1;
	logic                 valid_s2;
	stui_pkg::result_t    res_s2;
	logic                 stop_q;

	logic                 load_s2;
	logic                 adv_s1;
	logic                 take_in;
	stui_pkg::step_ctrl_t ctrl;
	stui_pkg::result_t    res_d;

	assign load_s2  = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && load_s2;
	assign in_stall = valid_s1 && !load_s2;
	assign take_in  = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign ctrl.advance = adv_s1;
	assign ctrl.item    = item_s1;

	stui_step u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stop_at_border (stop_q),
		.result         (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			stop_q <= stop_at_border;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (load_s2)
				valid_s2 <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.cmd          <= cmd;
			item_s1.reload_value <= reload_value;
			item_s1.ack_mask     <= ack_mask;
		end
		if (adv_s1)
			res_s2 <= res_d;
	end

	assign out_valid      = valid_s2;
	assign vblank_pending = res_s2.vblank_pending;
	assign timer_pending  = res_s2.timer_pending;
	assign line_now       = res_s2.line_now;
	assign timer_now      = res_s2.timer_now;

endmodule

`default_nettype wire

FILE: rtl/core/stui_step.sv
// Event state: line counter, timer, reload register and pending flags.
// Applies one event per advance beat. Depends on stui_pkg.
`default_nettype none

module stui_step (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire stui_pkg::step_ctrl_t ctrl,
	input  wire                       stop_at_border,
	output stui_pkg::result_t         result
);

	logic [stui_pkg::LINE_W-1:0]  line_q;
	logic [stui_pkg::TIMER_W-1:0] timer_q;
	logic [stui_pkg::TIMER_W-1:0] reload_q;
	logic                         vblank_q;
	logic                         tflag_q;

	logic [stui_pkg::LINE_W-1:0]  line_d;
	logic [stui_pkg::TIMER_W-1:0] timer_d;
	logic [stui_pkg::TIMER_W-1:0] reload_d;
	logic                         vblank_d;
	logic                         tflag_d;

	logic [stui_pkg::LINE_W-1:0]  line_inc;
	logic [stui_pkg::LINE_W-1:0]  line_tick;
	logic                         border;
	logic                         run;

	always_comb begin
		line_inc  = line_q + stui_pkg::LINE_W'(1);
		line_tick = (line_inc >= stui_pkg::LINE_W'(stui_pkg::LINES_PER_FRAME)) ?
			'0 : line_inc;
		border = ({1'b0, line_tick} < (stui_pkg::LINE_W + 1)'(stui_pkg::BORDER_LINES)) ||
			({1'b0, line_tick} >=
			(stui_pkg::LINE_W + 1)'(stui_pkg::VBLANK_LINE + stui_pkg::BORDER_LINES));
		run = !(stop_at_border && border) && (timer_q != '0);

		line_d   = line_q;
		timer_d  = timer_q;
		reload_d = reload_q;
		vblank_d = vblank_q;
		tflag_d  = tflag_q;

		case (stui_pkg::cmd_t'(ctrl.item.cmd))
			stui_pkg::CMD_TICK: begin
				line_d = line_tick;
				if (line_tick == stui_pkg::LINE_W'(stui_pkg::VBLANK_LINE))
					vblank_d = 1'b1;
				if (run) begin
					if (timer_q > stui_pkg::TIMER_W'(stui_pkg::TICKS_PER_LINE)) begin
						timer_d = timer_q - stui_pkg::TIMER_W'(stui_pkg::TICKS_PER_LINE);
					end else begin
						tflag_d = 1'b1;
						timer_d = reload_q;
					end
				end
			end
			stui_pkg::CMD_RELOAD: begin
				reload_d = ctrl.item.reload_value;
				timer_d  = ctrl.item.reload_value;
			end
			stui_pkg::CMD_ACK: begin
				if (ctrl.item.ack_mask[stui_pkg::ACK_VBLANK_BIT])
					vblank_d = 1'b0;
				if (ctrl.item.ack_mask[stui_pkg::ACK_TIMER_BIT])
					tflag_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= '0;
			timer_q  <= '0;
			reload_q <= '0;
			vblank_q <= 1'b0;
			tflag_q  <= 1'b0;
		end else if (ctrl.advance) begin
			line_q   <= line_d;
			timer_q  <= timer_d;
			reload_q <= reload_d;
			vblank_q <= vblank_d;
			tflag_q  <= tflag_d;
		end
	end

	assign result.vblank_pending = vblank_d;
	assign result.timer_pending  = tflag_d;
	assign result.line_now       = line_d;
	assign result.timer_now      = timer_d;

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_q < stui_pkg::LINE_W'(stui_pkg::LINES_PER_FRAME))
		else $error("line counter out of frame");

	a_line_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.advance && ctrl.item.cmd != stui_pkg::CMD_TICK) |=> $stable(line_q))
		else $error("line moved on a non-tick event");

	a_vblank_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vblank_q) |-> ($past(ctrl.advance)
		&& $past(ctrl.item.cmd) == stui_pkg::CMD_TICK
		&& line_q == stui_pkg::LINE_W'(stui_pkg::VBLANK_LINE)))
		else $error("vblank pending set outside the vblank line");

	a_timer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.advance |=> $stable(timer_q))
		else $error("timer changed without an event");

endmodule

`default_nettype wire
